### sv/fastfood_hadamard_projection_top_macros.svh
// Assertion macros used by the top level of the projection block.
`ifndef FASTFOOD_HADAMARD_PROJECTION_TOP_MACROS_SVH
`define FASTFOOD_HADAMARD_PROJECTION_TOP_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define FHP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("projection check failed");

// Consequent must hold in the cycle after the antecedent.
`define FHP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("projection check failed");

// Expression must never be true.
`define FHP_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("projection check failed");

`else

`define FHP_ASSERT_IMP(lbl, ante, cons)
`define FHP_ASSERT_NXT(lbl, ante, cons)
`define FHP_ASSERT_NEVER(lbl, expr)

`endif

`endif

### sv/fhp_pkg.sv
// Shared types, constants and helper functions of the projection block.
package fhp_pkg;

  // Row and table geometry.
  localparam int MAX_LEN  = 64;
  localparam int ADDR_W   = $clog2(MAX_LEN);
  localparam int SIZE_W   = 3;
  localparam int SIZE_MIN = 1;
  localparam int SIZE_MAX = $clog2(MAX_LEN);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(6);

  // Arithmetic widths.
  localparam int GAIN_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int VALUE_W  = 32;
  localparam int Q_SHIFT  = 12;
  // Magnitude after the first transform is at most 2^15 * MAX_LEN.
  localparam int MID_W    = SAMPLE_W + ADDR_W + 1;
  localparam int PROD_W   = GAIN_W + MID_W;
  localparam int SCALED_W = PROD_W - Q_SHIFT;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_BITS     = ADDR_W + 1 + GAIN_W + ADDR_W + SAMPLE_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = VALUE_W + ADDR_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic {
    MODE_LOAD,
    MODE_SAMPLE
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BFLY,
    ST_GATHER,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]        perm;
    logic signed [GAIN_W-1:0] gain;
    logic                     negate;
  } tbl_entry_t;

  typedef struct packed {
    mode_e                      mode;
    logic [ADDR_W-1:0]          position;
    logic                       negate;
    logic signed [GAIN_W-1:0]   gain;
    logic [ADDR_W-1:0]          source_position;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [ADDR_W-1:0]         position;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic                      we;
    logic [ADDR_W-1:0]         waddr;
    logic signed [VALUE_W-1:0] wdata;
    logic [ADDR_W-1:0]         raddr0;
    logic [ADDR_W-1:0]         raddr1;
  } buf_req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    tbl_entry_t        wdata;
    logic [ADDR_W-1:0] raddr0;
    logic [ADDR_W-1:0] raddr1;
  } tbl_req_t;

  typedef struct packed {
    logic      push;
    out_item_t item;
  } out_req_t;

  typedef struct packed {
    logic              busy;
    logic [ADDR_W-1:0] fill;
    logic [ADDR_W-1:0] mask;
  } eng_stat_t;

  // Clamp the size register into the supported range of log2 lengths.
  function automatic logic [SIZE_W-1:0] size_sat(input logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] s;
    s = raw;
    if (s < SIZE_W'(SIZE_MIN)) s = SIZE_W'(SIZE_MIN);
    if (s > SIZE_W'(SIZE_MAX)) s = SIZE_W'(SIZE_MAX);
    return s;
  endfunction

  // Row length minus one for a clamped log2 length.
  function automatic logic [ADDR_W-1:0] len_mask(input logic [SIZE_W-1:0] s);
    logic [ADDR_W:0] n;
    n = (ADDR_W + 1)'(1) << s;
    return ADDR_W'(n - (ADDR_W + 1)'(1));
  endfunction

endpackage

### sv/fastfood_hadamard_projection_top.sv
// Top level of the structured random projection block.
//
// Mode-0 transfers load one entry of the sign, gain and permutation tables. Mode-1
// transfers collect the samples of a row, one per cycle while the block is idle, into
// a 64-entry buffer memory. When the last of N samples arrives the block stops taking
// input and runs the row out of two ping-pong buffer memories, one element written per
// cycle: log2(N) butterfly passes (the first folds in the signs), a gain gather,
// another log2(N) butterfly passes, and then N results at one per cycle while the
// output is ready.
// Results keep flowing from a two-entry output queue while the next row is loading.
`include "fastfood_hadamard_projection_top_macros.svh"

module fastfood_hadamard_projection_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fhp_pkg::SIZE_W-1:0]         cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: position, negate, gain, source_position, sample.
  input  logic [fhp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Fields from bit 0: mode.
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0: value, out_position.
  output logic [fhp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast
);

  localparam int AW = fhp_pkg::ADDR_W;
  localparam int GW = fhp_pkg::GAIN_W;
  localparam int VW = fhp_pkg::VALUE_W;
  localparam int P_NEG  = AW;
  localparam int P_GAIN = P_NEG + 1;
  localparam int P_SRC  = P_GAIN + GW;
  localparam int P_SMP  = P_SRC + AW;

  fhp_pkg::in_item_t   in_item;
  fhp_pkg::tbl_req_t   tbl_req;
  fhp_pkg::tbl_entry_t tbl_rd0, tbl_rd1;
  fhp_pkg::buf_req_t   buf_a_req, buf_b_req;
  logic [VW-1:0]       buf_a_rd0, buf_a_rd1, buf_b_rd0, buf_b_rd1;
  fhp_pkg::out_req_t   out_req;
  fhp_pkg::out_item_t  out_item;
  fhp_pkg::eng_stat_t  stat;
  logic                q_ready;

  // Input payload unpacking.
  assign in_item.mode            = fhp_pkg::mode_e'(s_axis_tuser[0]);
  assign in_item.position        = s_axis_tdata[AW-1:0];
  assign in_item.negate          = s_axis_tdata[P_NEG];
  assign in_item.gain            = s_axis_tdata[P_GAIN +: GW];
  assign in_item.source_position = s_axis_tdata[P_SRC +: AW];
  assign in_item.sample          = s_axis_tdata[P_SMP +: fhp_pkg::SAMPLE_W];

  // Tables, one word per position.
  fhp_ram #(
    .WIDTH($bits(fhp_pkg::tbl_entry_t)),
    .DEPTH(fhp_pkg::MAX_LEN)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_req.we),
    .waddr_i (tbl_req.waddr),
    .wdata_i (tbl_req.wdata),
    .raddr0_i(tbl_req.raddr0),
    .raddr1_i(tbl_req.raddr1),
    .rdata0_o(tbl_rd0),
    .rdata1_o(tbl_rd1)
  );

  // Work buffers used in ping-pong fashion.
  fhp_ram #(
    .WIDTH(VW),
    .DEPTH(fhp_pkg::MAX_LEN)
  ) u_buf_a_ram (
    .clk_i   (clk_i),
    .we_i    (buf_a_req.we),
    .waddr_i (buf_a_req.waddr),
    .wdata_i (buf_a_req.wdata),
    .raddr0_i(buf_a_req.raddr0),
    .raddr1_i(buf_a_req.raddr1),
    .rdata0_o(buf_a_rd0),
    .rdata1_o(buf_a_rd1)
  );

  fhp_ram #(
    .WIDTH(VW),
    .DEPTH(fhp_pkg::MAX_LEN)
  ) u_buf_b_ram (
    .clk_i   (clk_i),
    .we_i    (buf_b_req.we),
    .waddr_i (buf_b_req.waddr),
    .wdata_i (buf_b_req.wdata),
    .raddr0_i(buf_b_req.raddr0),
    .raddr1_i(buf_b_req.raddr1),
    .rdata0_o(buf_b_rd0),
    .rdata1_o(buf_b_rd1)
  );

  fhp_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid),
    .in_item_i  (in_item),
    .in_ready_o (s_axis_tready),
    .tbl_req_o  (tbl_req),
    .tbl_rd0_i  (tbl_rd0),
    .tbl_rd1_i  (tbl_rd1),
    .buf_a_req_o(buf_a_req),
    .buf_b_req_o(buf_b_req),
    .buf_a_rd0_i($signed(buf_a_rd0)),
    .buf_a_rd1_i($signed(buf_a_rd1)),
    .buf_b_rd0_i($signed(buf_b_rd0)),
    .buf_b_rd1_i($signed(buf_b_rd1)),
    .q_ready_i  (q_ready),
    .out_req_o  (out_req),
    .stat_o     (stat)
  );

  fhp_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (out_req),
    .m_ready_i(m_axis_tready),
    .m_valid_o(m_axis_tvalid),
    .m_item_o (out_item),
    .ready_o  (q_ready)
  );

  // Output payload packing.
  assign m_axis_tdata = {(fhp_pkg::OUT_TDATA_W - fhp_pkg::OUT_BITS)'(0),
                         out_item.position, out_item.value};
  assign m_axis_tlast = out_item.last;

  // A result read from the buffers shows up on the output in the next cycle.
  `FHP_ASSERT_NXT(a_push_visible, out_req.push, m_axis_tvalid)
  // The row's closing result carries the last position of the row.
  `FHP_ASSERT_IMP(a_last_position, m_axis_tvalid && m_axis_tlast,
                  out_item.position == stat.mask)
  // The sample that completes a row starts processing.
  `FHP_ASSERT_NXT(a_row_starts, s_axis_tvalid && s_axis_tready &&
                  in_item.mode == fhp_pkg::MODE_SAMPLE && stat.fill == stat.mask, stat.busy)
  // Tables are never rewritten while a row is in flight.
  `FHP_ASSERT_NEVER(a_no_load_busy, tbl_req.we && stat.busy)

endmodule

### sv/fhp_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
module fhp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk_i) begin
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

### sv/fhp_outq.sv
// Two-entry result queue that decouples memory reads from the output stream.
module fhp_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fhp_pkg::out_req_t  req_i,
  input  logic               m_ready_i,
  output logic               m_valid_o,
  output fhp_pkg::out_item_t m_item_o,
  output logic               ready_o
);

  logic [1:0]         cnt_q, cnt_d;
  fhp_pkg::out_item_t ent0_q, ent0_d;
  fhp_pkg::out_item_t ent1_q, ent1_d;
  logic               pop;
  logic [2:0]         occ;

  assign m_valid_o = (cnt_q != 2'd0);
  assign m_item_o  = ent0_q;
  assign pop       = m_valid_o && m_ready_i;

  // A read issued now lands in the next cycle, so the read in flight counts as taken.
  assign occ     = 3'(cnt_q) + 3'(req_i.push) - 3'(pop);
  assign ready_o = (occ < 3'd2);

  // Queue update on push and pop.
  always_comb begin
    cnt_d  = cnt_q;
    ent0_d = ent0_q;
    ent1_d = ent1_q;
    case ({req_i.push, pop})
      2'b10: begin
        if (cnt_q == 2'd0) ent0_d = req_i.item;
        else ent1_d = req_i.item;
        cnt_d = cnt_q + 2'd1;
      end
      2'b01: begin
        ent0_d = ent1_q;
        cnt_d  = cnt_q - 2'd1;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          ent0_d = req_i.item;
        end else begin
          ent0_d = ent1_q;
          ent1_d = req_i.item;
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent0_q <= ent0_d;
    ent1_q <= ent1_d;
  end

endmodule

### sv/fhp_engine.sv
// Sequencer and datapath: sample capture, butterfly passes, gain gather and emission.
module fhp_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fhp_pkg::SIZE_W-1:0]           cfg_wdata_i,
  input  logic                                 in_valid_i,
  input  fhp_pkg::in_item_t                    in_item_i,
  output logic                                 in_ready_o,
  output fhp_pkg::tbl_req_t                    tbl_req_o,
  input  fhp_pkg::tbl_entry_t                  tbl_rd0_i,
  input  fhp_pkg::tbl_entry_t                  tbl_rd1_i,
  output fhp_pkg::buf_req_t                    buf_a_req_o,
  output fhp_pkg::buf_req_t                    buf_b_req_o,
  input  logic signed [fhp_pkg::VALUE_W-1:0]   buf_a_rd0_i,
  input  logic signed [fhp_pkg::VALUE_W-1:0]   buf_a_rd1_i,
  input  logic signed [fhp_pkg::VALUE_W-1:0]   buf_b_rd0_i,
  input  logic signed [fhp_pkg::VALUE_W-1:0]   buf_b_rd1_i,
  input  logic                                 q_ready_i,
  output fhp_pkg::out_req_t                    out_req_o,
  output fhp_pkg::eng_stat_t                   stat_o
);

  fhp_pkg::state_e                   state_q, state_d;
  logic [fhp_pkg::SIZE_W-1:0]        size_q, size_d;
  logic [fhp_pkg::ADDR_W-1:0]        fill_q, fill_d;
  logic [fhp_pkg::ADDR_W-1:0]        idx_q, idx_d;
  logic                              done_q, done_d;
  logic [fhp_pkg::SIZE_W-1:0]        pass_q, pass_d;
  logic                              second_q, second_d;
  logic                              src_q, src_d;
  logic                              s1_v_q, s1_v_d;
  logic                              s2_v_q, s2_v_d;
  logic [fhp_pkg::ADDR_W-1:0]        s1_idx_q;
  logic [fhp_pkg::ADDR_W-1:0]        s2_idx_q;
  logic signed [fhp_pkg::GAIN_W-1:0] s2_gain_q;

  logic [fhp_pkg::SIZE_W-1:0]        s_eff;
  logic [fhp_pkg::SIZE_W-1:0]        pass_last;
  logic [fhp_pkg::ADDR_W-1:0]        mask;
  logic [fhp_pkg::ADDR_W-1:0]        h;
  logic                              in_fire;
  logic                              issue;
  logic                              pipe_empty;
  logic                              apply_sign;

  logic signed [fhp_pkg::VALUE_W-1:0]  src_rd0, src_rd1;
  logic signed [fhp_pkg::VALUE_W-1:0]  a_v, b_v, bfly_res;
  logic signed [fhp_pkg::MID_W-1:0]    g_x;
  logic signed [fhp_pkg::PROD_W-1:0]   prod;
  logic signed [fhp_pkg::SCALED_W-1:0] scaled;

  logic                               wr_v;
  logic                               wr_to_a;
  logic [fhp_pkg::ADDR_W-1:0]         wr_addr;
  logic signed [fhp_pkg::VALUE_W-1:0] wr_data;
  logic [fhp_pkg::ADDR_W-1:0]         rd_addr0;
  logic [fhp_pkg::ADDR_W-1:0]         rd_addr1;

  // Row geometry from the size register.
  assign s_eff     = fhp_pkg::size_sat(size_q);
  assign pass_last = s_eff - fhp_pkg::SIZE_W'(1);
  assign mask      = fhp_pkg::len_mask(s_eff);
  assign h         = fhp_pkg::ADDR_W'(1) << pass_q;

  assign in_ready_o = (state_q == fhp_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign pipe_empty = !s1_v_q && !s2_v_q;
  assign apply_sign = (pass_q == '0) && !second_q;

  // Sequencer: passes, element counter and buffer ping-pong.
  always_comb begin
    state_d  = state_q;
    size_d   = size_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    done_d   = done_q;
    pass_d   = pass_q;
    second_d = second_q;
    src_d    = src_q;
    issue    = 1'b0;
    case (state_q)
      fhp_pkg::ST_IDLE: begin
        if (in_fire && in_item_i.mode == fhp_pkg::MODE_SAMPLE) begin
          if (fill_q == mask) begin
            fill_d   = '0;
            state_d  = fhp_pkg::ST_BFLY;
            pass_d   = '0;
            second_d = 1'b0;
            src_d    = 1'b0;
            idx_d    = '0;
            done_d   = 1'b0;
          end else begin
            fill_d = fill_q + fhp_pkg::ADDR_W'(1);
          end
        end
      end
      fhp_pkg::ST_BFLY, fhp_pkg::ST_GATHER: begin
        issue = !done_q;
        // A pass ends once every element is issued and the last write has landed.
        if (done_q && pipe_empty) begin
          src_d  = !src_q;
          done_d = 1'b0;
          if (state_q == fhp_pkg::ST_GATHER) begin
            second_d = 1'b1;
            pass_d   = '0;
            state_d  = fhp_pkg::ST_BFLY;
          end else if (pass_q == pass_last) begin
            pass_d  = '0;
            state_d = second_q ? fhp_pkg::ST_EMIT : fhp_pkg::ST_GATHER;
          end else begin
            pass_d = pass_q + fhp_pkg::SIZE_W'(1);
          end
        end
      end
      fhp_pkg::ST_EMIT: begin
        issue = !done_q && q_ready_i;
        if (done_q && pipe_empty) begin
          state_d = fhp_pkg::ST_IDLE;
          done_d  = 1'b0;
        end
      end
      default: begin
        state_d = fhp_pkg::ST_IDLE;
      end
    endcase
    if (issue) begin
      if (idx_q == mask) begin
        idx_d  = '0;
        done_d = 1'b1;
      end else begin
        idx_d = idx_q + fhp_pkg::ADDR_W'(1);
      end
    end
    // A size write drops any partial row.
    if (cfg_we_i) begin
      size_d = cfg_wdata_i;
      fill_d = '0;
    end
  end

  assign s1_v_d = issue;
  assign s2_v_d = s1_v_q && (state_q == fhp_pkg::ST_GATHER);

  // Source buffer read data.
  assign src_rd0 = src_q ? buf_b_rd0_i : buf_a_rd0_i;
  assign src_rd1 = src_q ? buf_b_rd1_i : buf_a_rd1_i;

  // Butterfly on the element and its partner; the first pass folds in the signs.
  always_comb begin
    a_v = src_rd0;
    b_v = src_rd1;
    if (apply_sign && tbl_rd0_i.negate) a_v = -src_rd0;
    if (apply_sign && tbl_rd1_i.negate) b_v = -src_rd1;
    if ((s1_idx_q & h) == '0) bfly_res = a_v + b_v;
    else bfly_res = b_v - a_v;
  end

  // Gain scaling; the arithmetic shift rounds toward minus infinity.
  assign g_x    = $signed(src_rd0[fhp_pkg::MID_W-1:0]);
  assign prod   = fhp_pkg::PROD_W'(g_x) * fhp_pkg::PROD_W'(s2_gain_q);
  assign scaled = prod[fhp_pkg::PROD_W-1:fhp_pkg::Q_SHIFT];

  // Buffer write selection.
  always_comb begin
    wr_v    = 1'b0;
    wr_to_a = src_q;
    wr_addr = s1_idx_q;
    wr_data = bfly_res;
    case (state_q)
      fhp_pkg::ST_IDLE: begin
        wr_v    = in_fire && (in_item_i.mode == fhp_pkg::MODE_SAMPLE);
        wr_to_a = 1'b1;
        wr_addr = fill_q;
        wr_data = fhp_pkg::VALUE_W'(in_item_i.sample);
      end
      fhp_pkg::ST_BFLY: begin
        wr_v = s1_v_q;
      end
      fhp_pkg::ST_GATHER: begin
        wr_v    = s2_v_q;
        wr_addr = s2_idx_q;
        wr_data = fhp_pkg::VALUE_W'(scaled);
      end
      default: begin
        wr_v = 1'b0;
      end
    endcase
  end

  // Read addresses: the gather reads its source through the permutation.
  assign rd_addr0 = (state_q == fhp_pkg::ST_GATHER) ? (tbl_rd0_i.perm & mask) : idx_q;
  assign rd_addr1 = idx_q ^ h;

  // Memory requests.
  always_comb begin
    buf_a_req_o.we     = wr_v && wr_to_a;
    buf_a_req_o.waddr  = wr_addr;
    buf_a_req_o.wdata  = wr_data;
    buf_a_req_o.raddr0 = rd_addr0;
    buf_a_req_o.raddr1 = rd_addr1;
    buf_b_req_o.we     = wr_v && !wr_to_a;
    buf_b_req_o.waddr  = wr_addr;
    buf_b_req_o.wdata  = wr_data;
    buf_b_req_o.raddr0 = rd_addr0;
    buf_b_req_o.raddr1 = rd_addr1;
    // Every six-bit position lies inside the tables.
    tbl_req_o.we              = in_fire && (in_item_i.mode == fhp_pkg::MODE_LOAD);
    tbl_req_o.waddr           = in_item_i.position;
    tbl_req_o.wdata.perm      = in_item_i.source_position;
    tbl_req_o.wdata.gain      = in_item_i.gain;
    tbl_req_o.wdata.negate    = in_item_i.negate;
    tbl_req_o.raddr0          = idx_q;
    tbl_req_o.raddr1          = rd_addr1;
  end

  // Result transfer into the queue as read data returns.
  always_comb begin
    out_req_o.push          = s1_v_q && (state_q == fhp_pkg::ST_EMIT);
    out_req_o.item.value    = src_rd0;
    out_req_o.item.position = s1_idx_q;
    out_req_o.item.last     = (s1_idx_q == mask);
  end

  assign stat_o.busy = (state_q != fhp_pkg::ST_IDLE);
  assign stat_o.fill = fill_q;
  assign stat_o.mask = mask;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fhp_pkg::ST_IDLE;
      size_q   <= fhp_pkg::SIZE_RESET;
      fill_q   <= '0;
      idx_q    <= '0;
      done_q   <= 1'b0;
      pass_q   <= '0;
      second_q <= 1'b0;
      src_q    <= 1'b0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      size_q   <= size_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      done_q   <= done_d;
      pass_q   <= pass_d;
      second_q <= second_d;
      src_q    <= src_d;
      s1_v_q   <= s1_v_d;
      s2_v_q   <= s2_v_d;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    s1_idx_q  <= idx_q;
    s2_idx_q  <= s1_idx_q;
    s2_gain_q <= tbl_rd0_i.gain;
  end

endmodule
